/* design/sqmm_pkg.sv */
`timescale 1ns / 1ps
package sqmm_pkg;

  // field and datapath widths
  localparam int SIZE_W  = 5;
  localparam int ROW_W   = 4;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 32;
  localparam int ACC_W   = 40;
  // order and loop count width, wide enough for orders up to 64
  localparam int N_W     = 7;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // input item kinds
  typedef enum logic [1:0] {
    KIND_WR_A = 2'd0,
    KIND_WR_B = 2'd1,
    KIND_RD   = 2'd2
  } kind_t;

  // commands handed to the back end
  typedef enum logic [1:0] {
    OP_WR_A    = 2'd0,
    OP_WR_B    = 2'd1,
    OP_RD      = 2'd2,
    OP_RD_ZERO = 2'd3
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [ROW_W-1:0]        row;
    logic [ROW_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic [N_W-1:0]          n;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    B_IDLE  = 2'd0,
    B_RUN   = 2'd1,
    B_DRAIN = 2'd2,
    B_DONE  = 2'd3
  } back_state_t;

endpackage

/* design/sqmm_if.sv */
`timescale 1ns / 1ps
// request channel: writes of A or B elements and product reads
interface sqmm_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [3:0]         row_index;
  logic [3:0]         col_index;
  logic signed [15:0] element_value;

  modport source (output valid, kind, row_index, col_index, element_value, input ready);
  modport sink   (input valid, kind, row_index, col_index, element_value, output ready);
endinterface

// response channel: one product element per read
interface sqmm_rsp_if;
  logic               valid;
  logic               ready;
  logic [3:0]         out_row;
  logic [3:0]         out_col;
  logic signed [39:0] product_value;

  modport source (output valid, out_row, out_col, product_value, input ready);
  modport sink   (input valid, out_row, out_col, product_value, output ready);
endinterface

/* design/sqmm_front.sv */
`timescale 1ns / 1ps
module sqmm_front #(
  parameter int MAX_N = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [sqmm_pkg::SIZE_W-1:0] cfg_data,
  sqmm_req_if.sink                    req,
  input  sqmm_pkg::q_status_t         q_status,
  output logic                        push,
  output sqmm_pkg::cmd_t              push_cmd
);
  import sqmm_pkg::*;

  localparam logic [N_W-1:0] MAX_N_V = N_W'(MAX_N);

  logic [SIZE_W-1:0] size_in_use;
  logic [N_W-1:0]    size_ext;
  logic [N_W-1:0]    eff_n;
  logic [N_W-1:0]    row_ext;
  logic [N_W-1:0]    col_ext;
  logic              in_store;
  logic              in_order;
  logic              keep;

  // order register
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_RESET;
    end else if (cfg_we) begin
      size_in_use <= cfg_data;
    end
  end

  // effective order saturates at the store size
  assign size_ext = N_W'(size_in_use);
  assign eff_n    = (size_ext > MAX_N_V) ? MAX_N_V : size_ext;
  assign row_ext  = N_W'(req.row_index);
  assign col_ext  = N_W'(req.col_index);
  assign in_store = (row_ext < MAX_N_V) && (col_ext < MAX_N_V);
  assign in_order = (row_ext < eff_n) && (col_ext < eff_n);

  // classify the item into a command, drop what has no effect
  always_comb begin
    keep           = 1'b0;
    push_cmd.op    = OP_RD_ZERO;
    push_cmd.row   = req.row_index;
    push_cmd.col   = req.col_index;
    push_cmd.value = req.element_value;
    push_cmd.n     = eff_n;
    unique case (req.kind)
      KIND_WR_A: begin
        keep        = in_store;
        push_cmd.op = OP_WR_A;
      end
      KIND_WR_B: begin
        keep        = in_store;
        push_cmd.op = OP_WR_B;
      end
      KIND_RD: begin
        keep        = 1'b1;
        push_cmd.op = in_order ? OP_RD : OP_RD_ZERO;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign req.ready = !q_status.full;
  assign push      = req.valid && !q_status.full && keep;

endmodule

/* design/sqmm_fifo.sv */
`timescale 1ns / 1ps
module sqmm_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sqmm_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output sqmm_pkg::cmd_t      pop_cmd,
  output sqmm_pkg::q_status_t q_status
);
  import sqmm_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign q_status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_status.empty = (count == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign pop_cmd        = slots[rd_ptr];

  // payload slots
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

/* design/sqmm_back.sv */
`timescale 1ns / 1ps
module sqmm_back #(
  parameter int MAX_N = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  sqmm_pkg::q_status_t q_status,
  input  sqmm_pkg::cmd_t      cmd,
  output logic                pop,
  sqmm_rsp_if.source          rsp
);
  import sqmm_pkg::*;

  localparam int DEPTH  = MAX_N * MAX_N;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] STRIDE = ADDR_W'(MAX_N);

  back_state_t state;
  back_state_t state_next;

  logic signed [VAL_W-1:0] mem_a [DEPTH];
  logic signed [VAL_W-1:0] mem_b [DEPTH];

  logic [ROW_W-1:0]         row_q;
  logic [ROW_W-1:0]         col_q;
  logic [N_W-1:0]           n_q;
  logic [N_W-1:0]           k;
  logic signed [VAL_W-1:0]  a_q;
  logic signed [VAL_W-1:0]  b_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic                     rd_v;
  logic                     rd_last;
  logic                     mul_v;
  logic                     mul_last;
  logic                     out_valid;

  logic              issue;
  logic              issue_last;
  logic              load;
  logic              wr_a;
  logic              wr_b;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] a_addr;
  logic [ADDR_W-1:0] b_addr;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: take a command, walk k, drain the mac, hand off the result
  always_comb begin
    pop        = 1'b0;
    issue      = 1'b0;
    issue_last = 1'b0;
    load       = 1'b0;
    state_next = state;
    unique case (state)
      B_IDLE: begin
        pop = !q_status.empty;
        if (pop) begin
          case (cmd.op)
            OP_RD:      state_next = B_RUN;
            OP_RD_ZERO: state_next = B_DONE;
            default:    state_next = B_IDLE;
          endcase
        end
      end
      B_RUN: begin
        issue      = 1'b1;
        issue_last = (k == n_q - N_W'(1));
        if (issue_last) begin
          state_next = B_DRAIN;
        end
      end
      B_DRAIN: begin
        if (mul_v && mul_last) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        load = !out_valid || rsp.ready;
        if (load) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // store addresses, row-major with a stride of the store order
  assign wr_a    = pop && (cmd.op == OP_WR_A);
  assign wr_b    = pop && (cmd.op == OP_WR_B);
  assign wr_addr = ADDR_W'(cmd.row) * STRIDE + ADDR_W'(cmd.col);
  assign a_addr  = ADDR_W'(row_q) * STRIDE + ADDR_W'(k);
  assign b_addr  = ADDR_W'(k) * STRIDE + ADDR_W'(col_q);

  // element stores, one write and one registered read each
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[wr_addr] <= cmd.value;
    end
    if (wr_b) begin
      mem_b[wr_addr] <= cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    a_q <= mem_a[a_addr];
    b_q <= mem_b[b_addr];
  end

  // multiply stage
  always_ff @(posedge clk) begin
    prod <= a_q * b_q;
  end

  // read context, loop counter and accumulator
  always_ff @(posedge clk) begin
    if (pop) begin
      row_q <= cmd.row;
      col_q <= cmd.col;
      n_q   <= cmd.n;
      k     <= '0;
      acc   <= '0;
    end else begin
      if (issue) begin
        k <= k + N_W'(1);
      end
      if (mul_v) begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v     <= 1'b0;
      rd_last  <= 1'b0;
      mul_v    <= 1'b0;
      mul_last <= 1'b0;
    end else begin
      rd_v     <= issue;
      rd_last  <= issue_last;
      mul_v    <= rd_v;
      mul_last <= rd_last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.out_row       <= row_q;
      rsp.out_col       <= col_q;
      rsp.product_value <= acc;
    end
  end

  assign rsp.valid = out_valid;

  // the mac is empty by the time a result is handed off
  assert property (@(posedge clk) disable iff (rst)
    (state == B_DONE) |-> !(rd_v || mul_v))
    else $error("mac pipeline busy while result is handed off");

  // a product read starts from a clean loop
  assert property (@(posedge clk) disable iff (rst)
    (pop && cmd.op == OP_RD) |=> (state == B_RUN && k == '0 && acc == '0))
    else $error("product read did not start cleanly");

  // the loop never walks past the order
  assert property (@(posedge clk) disable iff (rst)
    (state == B_RUN) |-> (k < n_q))
    else $error("loop index beyond order");

  // a new result only comes out of the hand-off state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == B_DONE))
    else $error("result raised outside hand-off");

endmodule

/* design/square_matrix_multiply_core.sv */
`timescale 1ns / 1ps
// Square matrix product engine, C = A x B, for orders up to MAX_N. Items on req
// either store one signed 16-bit element of A or B, or read one element of C,
// which comes back on rsp as an exact 40-bit signed dot product together with
// its row and column. The order is set through cfg_we/cfg_data (reset 16,
// saturating at MAX_N) and is taken at the time a read item is accepted.
// Reads outside the order return zero; writes outside the store and items of
// kind 3 are dropped without a result. A front end classifies items into a
// four-entry command queue, so req keeps accepting while the back end works
// and the queue is not full. In the back end a write is done when taken; a
// read runs a single multiply-accumulate walking k over one read port of each
// store, through the read and multiply stages, to the hand-off; a read outside
// the order goes straight to the hand-off. A finished result waits in an output
// register while the back end moves on to queued commands.
module square_matrix_multiply_core #(
  parameter int MAX_N = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,
  sqmm_req_if.sink    req,
  sqmm_rsp_if.source  rsp
);
  import sqmm_pkg::*;

  q_status_t q_status;
  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      pop_cmd;

  // item classification and order register
  sqmm_front #(
    .MAX_N (MAX_N)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // command queue
  sqmm_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_status (q_status)
  );

  // stores, mac and result register
  sqmm_back #(
    .MAX_N (MAX_N)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .cmd      (pop_cmd),
    .pop      (pop),
    .rsp      (rsp)
  );

endmodule

/* tb/tb_square_matrix_multiply_core.sv */
`timescale 1ns / 1ps
module tb_square_matrix_multiply_core;
  import sqmm_pkg::*;

  localparam int MAX_N       = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 100;
  localparam int N_DIR       = 20;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // one product element as it leaves the block
  typedef struct {
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [39:0] value;
  } product_t;

  // directed stimulus row; cfg rows carry the order in value
  typedef struct {
    bit                 is_cfg;
    logic [1:0]         kind;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] value;
    bit                 has_exp;
    logic signed [39:0] exp_val;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [4:0] cfg_data;

  sqmm_req_if req_ch ();
  sqmm_rsp_if rsp_ch ();

  square_matrix_multiply_core #(
    .MAX_N(MAX_N)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  // predicted store contents and order
  logic signed [15:0] a_elems [MAX_N][MAX_N];
  logic signed [15:0] b_elems [MAX_N][MAX_N];
  logic [4:0]         order_reg;
  product_t           pending_products [$];

  int mismatch_count = 0;
  int send_gap_pct   = 14;
  int rsp_stall_pct  = 82;
  int hold_epoch     = 0;

  // directed table: typed values only where obvious
  stim_row_t directed_rows [0:N_DIR-1] = '{
    '{1'b1, KIND_WR_A,   4'd0,  4'd0,  16'sd1,      1'b0, 40'sd0},
    '{1'b0, KIND_WR_A,   4'd0,  4'd0,  -16'sd32768, 1'b0, 40'sd0},
    '{1'b0, KIND_WR_B,   4'd0,  4'd0,  -16'sd32768, 1'b0, 40'sd0},
    '{1'b0, KIND_RD,     4'd0,  4'd0,  16'sd0,      1'b1, 40'sd1073741824},
    '{1'b0, KIND_WR_B,   4'd0,  4'd0,  16'sd32767,  1'b0, 40'sd0},
    '{1'b0, KIND_RD,     4'd0,  4'd0,  16'sd0,      1'b1, -40'sd1073709056},
    '{1'b0, KIND_RD,     4'd15, 4'd15, 16'sd0,      1'b1, 40'sd0},
    '{1'b0, KIND_RD,     4'd0,  4'd15, 16'sd0,      1'b1, 40'sd0},
    '{1'b0, KIND_WR_A,   4'd15, 4'd15, -16'sd1,     1'b0, 40'sd0},
    '{1'b0, KIND_UNUSED, 4'd5,  4'd5,  16'sd1234,   1'b0, 40'sd0},
    '{1'b0, KIND_WR_A,   4'd0,  4'd0,  16'sd32767,  1'b0, 40'sd0},
    '{1'b0, KIND_RD,     4'd0,  4'd0,  16'sd0,      1'b1, 40'sd1073676289},
    '{1'b1, KIND_WR_A,   4'd0,  4'd0,  16'sd0,      1'b0, 40'sd0},
    '{1'b0, KIND_RD,     4'd0,  4'd0,  16'sd0,      1'b1, 40'sd0},
    '{1'b0, KIND_RD,     4'd15, 4'd3,  16'sd0,      1'b1, 40'sd0},
    '{1'b1, KIND_WR_A,   4'd0,  4'd0,  16'sd2,      1'b0, 40'sd0},
    '{1'b0, KIND_WR_A,   4'd0,  4'd1,  -16'sd32768, 1'b0, 40'sd0},
    '{1'b0, KIND_WR_B,   4'd1,  4'd0,  16'sd32767,  1'b0, 40'sd0},
    '{1'b0, KIND_RD,     4'd0,  4'd0,  16'sd0,      1'b0, 40'sd0},
    '{1'b0, KIND_RD,     4'd2,  4'd1,  16'sd0,      1'b1, 40'sd0}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5000000;
    $display("[square_matrix_multiply_core] ERROR");
    $finish;
  end

  task automatic report_mismatch(input string field, input logic signed [39:0] got,
                                 input logic signed [39:0] want);
    if (mismatch_count < 100)
      $display("%0t: %s mismatch, got %0d, expected %0d", $time, field, got, want);
    mismatch_count++;
  endtask

  // exact dot product of a row of A and a column of B at the current order
  function automatic logic signed [39:0] dot_product(input logic [3:0] row,
                                                     input logic [3:0] col);
    int     n;
    longint acc;
    n   = (order_reg > MAX_N) ? MAX_N : int'(order_reg);
    acc = 0;
    if (row < n && col < n)
      for (int k = 0; k < n; k++)
        acc += longint'(a_elems[row][k]) * longint'(b_elems[k][col]);
    return acc[39:0];
  endfunction

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: pick_value = 16'sh8000;
      1: pick_value = 16'sh7fff;
      2: pick_value = 16'($urandom_range(0, 16)) - 16'd8;
      default: pick_value = 16'($urandom);
    endcase
  endfunction

  // update the predicted stores or queue the expected product
  task automatic take_item(input logic [1:0] kind, input logic [3:0] row,
                           input logic [3:0] col, input logic signed [15:0] value,
                           input bit has_exp, input logic signed [39:0] exp_val);
    product_t p;
    case (kind)
      KIND_WR_A: a_elems[row][col] = value;
      KIND_WR_B: b_elems[row][col] = value;
      KIND_RD: begin
        p.row   = row;
        p.col   = col;
        p.value = has_exp ? exp_val : dot_product(row, col);
        pending_products.push_back(p);
      end
      default: ;
    endcase
  endtask

  // offer one item and wait until it is taken
  task automatic send_item(input logic [1:0] kind, input logic [3:0] row,
                           input logic [3:0] col, input logic signed [15:0] value,
                           input bit has_exp = 1'b0,
                           input logic signed [39:0] exp_val = '0);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.kind          <= kind;
    req_ch.row_index     <= row;
    req_ch.col_index     <= col;
    req_ch.element_value <= value;
    do @(posedge clk); while (!req_ch.ready);
    take_item(kind, row, col, value, has_exp, exp_val);
  endtask

  // order change only once every product is back and the block has settled
  task automatic write_order(input logic [4:0] order);
    req_ch.valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= order;
    @(posedge clk);
    cfg_we    <= 1'b0;
    order_reg = order;
  endtask

  // random mix of writes, reads and unused-kind items at one order
  task automatic run_random_phase(input logic [4:0] order, input int count);
    int         n_eff;
    int         sent;
    int         sel;
    logic [3:0] row;
    logic [3:0] col;
    write_order(order);
    n_eff = (order > MAX_N) ? MAX_N : int'(order);
    sent  = 0;
    while (sent < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        send_item(KIND_UNUSED, 4'($urandom), 4'($urandom), pick_value());
      end else if (sel < 45) begin
        send_item((sel < 25) ? KIND_WR_A : KIND_WR_B, 4'($urandom), 4'($urandom),
                  pick_value());
        sent++;
      end else begin
        if (n_eff > 0 && $urandom_range(0, 3) != 0) begin
          row = 4'($urandom_range(0, n_eff - 1));
          col = 4'($urandom_range(0, n_eff - 1));
        end else begin
          row = 4'($urandom);
          col = 4'($urandom);
        end
        send_item(KIND_RD, row, col, pick_value());
        sent++;
      end
    end
  endtask

  // result side: check, then decide ready for the next cycle
  initial begin
    int       hold_seen;
    int       hold_left;
    product_t want;
    hold_seen    = 0;
    hold_left    = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        if (pending_products.size() == 0) begin
          report_mismatch("unexpected product", rsp_ch.product_value, '0);
        end else begin
          want = pending_products.pop_front();
          if (rsp_ch.out_row !== want.row)
            report_mismatch("out_row", rsp_ch.out_row, want.row);
          if (rsp_ch.out_col !== want.col)
            report_mismatch("out_col", rsp_ch.out_col, want.col);
          if (rsp_ch.product_value !== want.value)
            report_mismatch("product_value", rsp_ch.product_value, want.value);
        end
      end
      if (hold_epoch != hold_seen) begin
        hold_seen = hold_epoch;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
    end
  end

  // stimulus
  initial begin
    logic [4:0] phase_orders [8];
    phase_orders = '{5'd31, 5'd1, 5'd0, 5'd16, 5'd9, 5'd17, 5'd4, 5'd2};
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_data             = '0;
    req_ch.valid         = 1'b0;
    req_ch.kind          = KIND_WR_A;
    req_ch.row_index     = '0;
    req_ch.col_index     = '0;
    req_ch.element_value = '0;
    order_reg            = SIZE_RESET;
    foreach (a_elems[r, c]) begin
      a_elems[r][c] = '0;
      b_elems[r][c] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    for (int i = 0; i < N_DIR; i++) begin
      if (directed_rows[i].is_cfg)
        write_order(directed_rows[i].value[4:0]);
      else
        send_item(directed_rows[i].kind, directed_rows[i].row, directed_rows[i].col,
                  directed_rows[i].value, directed_rows[i].has_exp,
                  directed_rows[i].exp_val);
    end

    // fill both stores so every later read hits written entries
    write_order(5'd16);
    for (int r = 0; r < MAX_N; r++)
      for (int c = 0; c < MAX_N; c++) begin
        send_item(KIND_WR_A, 4'(r), 4'(c), pick_value());
        send_item(KIND_WR_B, 4'(r), 4'(c), pick_value());
      end

    // random phases across orders and idle patterns
    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        send_gap_pct  = 82;
        rsp_stall_pct = 14;
      end else if (p == 6) begin
        send_gap_pct  = 0;
        rsp_stall_pct = 0;
      end
      if (p == 3) begin
        write_order(phase_orders[p]);
        hold_epoch++;
      end
      run_random_phase(phase_orders[p], 150);
    end

    // drain and finish
    req_ch.valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("[square_matrix_multiply_core] OK");
    else
      $display("[square_matrix_multiply_core] ERROR");
    $finish;
  end

endmodule

/* square_matrix_multiply_core.f */
design/sqmm_pkg.sv
design/sqmm_if.sv
design/sqmm_front.sv
design/sqmm_fifo.sv
design/sqmm_back.sv
design/square_matrix_multiply_core.sv
tb/tb_square_matrix_multiply_core.sv
